[rtl/fpsa_pkg.sv]
// ----------------------------------------------------------------------------
// Free page stack allocator package
// Shared constants, action and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package fpsa_pkg;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W     = 40;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PPN_W      = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FREE_W     = 16;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_TOP = 1'd1;

    localparam logic [ADDR_W-1:0] KERNEL_END_RESET = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] MEMORY_TOP_RESET = 40'h00_8800_0000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic bounds;
        logic count;
        logic fill;
        logic finish;
    } fpsa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_done;
    } fpsa_sts_t;

endpackage

[rtl/fpsa_ctrl.sv]
// ----------------------------------------------------------------------------
// Free page stack allocator controller
// Sequences request intake, the init fill loop and result hand-off.
// ----------------------------------------------------------------------------
module fpsa_ctrl
    import fpsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    output logic                out_valid,
    input  logic                out_ready,
    input  fpsa_sts_t           sts,
    output fpsa_cmd_t           cmd
);

    typedef enum logic [4:0] {
        ST_IDLE        = 5'b00001,
        ST_EXEC        = 5'b00010,
        ST_INIT_BOUNDS = 5'b00100,
        ST_INIT_COUNT  = 5'b01000,
        ST_INIT_FILL   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (action == ACT_INIT) ? ST_INIT_BOUNDS : ST_EXEC;
                end
            end
            ST_INIT_BOUNDS:
            begin
                cmd.bounds = 1'b1;
                state_next = ST_INIT_COUNT;
            end
            ST_INIT_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = ST_INIT_FILL;
            end
            ST_INIT_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result waits here until the output register can take it.
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/fpsa_dp.sv]
// ----------------------------------------------------------------------------
// Free page stack allocator datapath
// Holds the stack RAM, stack depth, bound registers and the result register.
// ----------------------------------------------------------------------------
module fpsa_dp
    import fpsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpsa_cmd_t            cmd,
    output fpsa_sts_t            sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic [ACTION_W-1:0]  action,
    input  logic [ADDR_W-1:0]    page_address,
    output logic [ADDR_W-1:0]    granted_address,
    output logic [STATUS_W-1:0]  status,
    output logic [FREE_W-1:0]    free_pages
);

    logic [PPN_W-1:0]    stack_mem [MAX_PAGES];

    logic [ADDR_W-1:0]   kernel_end_reg;
    logic [ADDR_W-1:0]   memory_top_reg;
    logic [CNT_W-1:0]    depth_reg;
    logic [CNT_W-1:0]    depth_next;

    logic [ACTION_W-1:0] action_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PPN_W-1:0]    rd_data_reg;

    logic [PPN_W:0]      first_reg;
    logic [PPN_W-1:0]    last_reg;
    logic [CNT_W-1:0]    fill_n_reg;
    logic                init_full_reg;
    logic [CNT_W-1:0]    fill_idx_reg;
    logic [PPN_W-1:0]    fill_ppn_reg;

    logic [ADDR_W-1:0]   granted_reg;
    logic [ADDR_W-1:0]   granted_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [FREE_W-1:0]   free_pages_reg;

    logic [ADDR_W:0]     ke_round;
    logic [PPN_W:0]      span;
    logic                span_pos;
    logic                span_over;
    logic [CNT_W-1:0]    fill_n_next;
    logic [CNT_W:0]      fill_idx_inc;

    logic                free_bad;
    logic                stack_full;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [PPN_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    assign ke_round    = {1'b0, kernel_end_reg} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    assign span        = {1'b0, last_reg} - first_reg;
    assign span_pos    = ({1'b0, last_reg} > first_reg);
    assign span_over   = span_pos && (span > (PPN_W + 1)'(MAX_PAGES));
    assign fill_n_next = span_over ? CNT_W'(MAX_PAGES)
                       : (span_pos ? span[CNT_W-1:0] : '0);

    assign fill_idx_inc  = {1'b0, fill_idx_reg} + (CNT_W + 1)'(1);
    assign sts.fill_done = (fill_idx_inc >= {1'b0, fill_n_reg});

    assign free_bad   = (addr_reg[PAGE_SHIFT-1:0] != '0) || (addr_reg < kernel_end_reg)
                      || (addr_reg >= memory_top_reg);
    assign stack_full = (depth_reg >= CNT_W'(MAX_PAGES));

    // The top of the stack is read on every request; only an allocate uses it.
    assign mem_raddr = depth_reg[IDX_W-1:0] - IDX_W'(1);

    always_comb
    begin
        granted_next = '0;
        status_next  = STATUS_OK;
        depth_next   = depth_reg;
        mem_we       = 1'b0;
        mem_waddr    = fill_idx_reg[IDX_W-1:0];
        mem_wdata    = fill_ppn_reg;
        if (cmd.fill)
        begin
            mem_we = (fill_idx_reg < fill_n_reg);
        end
        if (cmd.finish)
        begin
            case (action_reg)
                ACT_ALLOC:
                begin
                    if (depth_reg == '0)
                    begin
                        status_next = STATUS_NO_PAGE;
                    end
                    else
                    begin
                        granted_next = {rd_data_reg, PAGE_SHIFT'(0)};
                        depth_next   = depth_reg - CNT_W'(1);
                    end
                end
                ACT_FREE:
                begin
                    if (free_bad)
                    begin
                        status_next = STATUS_REJECTED;
                    end
                    else if (stack_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = depth_reg[IDX_W-1:0];
                        mem_wdata  = addr_reg[ADDR_W-1:PAGE_SHIFT];
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
                ACT_INIT:
                begin
                    status_next = init_full_reg ? STATUS_FULL : STATUS_OK;
                    depth_next  = fill_n_reg;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action;
            addr_reg   <= page_address;
        end
        if (cmd.bounds)
        begin
            first_reg <= ke_round[ADDR_W:PAGE_SHIFT];
            last_reg  <= memory_top_reg[ADDR_W-1:PAGE_SHIFT];
        end
        if (cmd.count)
        begin
            fill_n_reg    <= fill_n_next;
            init_full_reg <= span_over;
            fill_idx_reg  <= '0;
            fill_ppn_reg  <= first_reg[PPN_W-1:0];
        end
        if (cmd.fill)
        begin
            fill_idx_reg <= fill_idx_inc[CNT_W-1:0];
            fill_ppn_reg <= fill_ppn_reg + PPN_W'(1);
        end
        if (cmd.finish)
        begin
            granted_reg    <= granted_next;
            status_reg     <= status_next;
            free_pages_reg <= FREE_W'(depth_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg <= KERNEL_END_RESET;
            memory_top_reg <= MEMORY_TOP_RESET;
            depth_reg      <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_KERNEL_END))
            begin
                kernel_end_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_MEMORY_TOP))
            begin
                memory_top_reg <= cfg_data;
            end
            depth_reg <= depth_next;
        end
    end

    assign granted_address = granted_reg;
    assign status          = status_reg;
    assign free_pages      = free_pages_reg;

endmodule

[rtl/free_page_stack_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Free page stack allocator
// LIFO stack of free physical pages with allocate, free and init requests.
// ----------------------------------------------------------------------------
// One request is in flight at a time. For allocate, free and unused action
// codes, the accept cycle reads the top of the stack RAM, and the EXEC state
// then updates the stack and loads the result register. Init passes through
// the BOUNDS, COUNT and FILL states before EXEC; the fill loop writes one
// stack entry per cycle through the RAM write port, one per page pushed. A
// result that is not taken holds the next request in the EXEC state. The stack
// RAM needs no clearing after reset; the block takes requests right away.
// Configuration writes take effect at once and belong to idle time.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_unit
    import fpsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic [ADDR_W-1:0]    page_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    granted_address,
    output logic [STATUS_W-1:0]  status,
    output logic [FREE_W-1:0]    free_pages
);

    fpsa_cmd_t cmd;
    fpsa_sts_t sts;

    fpsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fpsa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (action),
        .page_address    (page_address),
        .granted_address (granted_address),
        .status          (status),
        .free_pages      (free_pages)
    );

endmodule

[rtl/fpsa_checker.sv]
// ----------------------------------------------------------------------------
// Free page stack allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module fpsa_checker
    import fpsa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [ADDR_W-1:0]    granted_address,
    input logic [STATUS_W-1:0]  status,
    input logic [FREE_W-1:0]    free_pages
);

    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another was in flight");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(granted_address)
            && $stable(status) && $stable(free_pages)))
        else $error("stalled result changed");

    // A granted address only comes with a successful allocate.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (granted_address != '0)) |-> (status == STATUS_OK))
        else $error("address granted with a failing status");

    a_grant_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted_address[PAGE_SHIFT-1:0] == '0))
        else $error("granted address not page aligned");

    a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_NO_PAGE)) |-> (free_pages == '0))
        else $error("no free page reported while pages remain");

endmodule

bind free_page_stack_allocator_unit fpsa_checker u_fpsa_checker (.*);
